// ----- sv/ccp_pkg.sv -----
// Package with the shared types, codes and constants of the text console put engine.
package ccp_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_ADDR_W = 11;
    localparam int CURSOR_W    = 11;
    localparam int WORD_W      = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h07;
    localparam logic [WORD_W-1:0] RESET_WORD       = {BLANK_ATTR_RESET, CH_SPACE};

    localparam logic [APB_ADDR_W-3:0] REG_BLANK_ATTR = 1'b0;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_NONE  = 3'd0;
    localparam t_kind KIND_PRINT = 3'd1;
    localparam t_kind KIND_BACK  = 3'd2;
    localparam t_kind KIND_TAB   = 3'd3;
    localparam t_kind KIND_RET   = 3'd4;
    localparam t_kind KIND_LINE  = 3'd5;
    localparam t_kind KIND_CLEAR = 3'd6;
    localparam t_kind KIND_READ  = 3'd7;

    typedef struct packed {
        t_kind                  kind;
        logic [CHAR_W-1:0]      char_code;
        logic [ATTR_W-1:0]      attribute;
        logic [CELL_ADDR_W-1:0] cell_address;
    } t_cmd;

endpackage

// ----- sv/ccp_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
module ccp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ccp_front.sv -----
// Front end: takes requests, classifies them into commands and queues them for the back end.
module ccp_front #(
    parameter int CELLS = ccp_pkg::COLUMNS_DEF * ccp_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [ccp_pkg::ACTION_W-1:0]     i_action,
    input  logic [ccp_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [ccp_pkg::ATTR_W-1:0]       i_attribute,
    input  logic [ccp_pkg::CELL_ADDR_W-1:0]  i_cell_address,
    input  logic                             i_hold,
    output ccp_pkg::t_cmd                    o_cmd,
    output logic                             o_cmd_vld,
    input  logic                             i_cmd_take
);

    localparam int DEPTH = ccp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ccp_pkg::CELL_ADDR_W + 2;

    ccp_pkg::t_cmd    r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    ccp_pkg::t_kind   kind;
    logic             accept;
    logic             take;

    always_comb begin
        case (i_action)
            ccp_pkg::ACT_PUT: begin
                case (i_char_code)
                    ccp_pkg::CH_BS:  kind = ccp_pkg::KIND_BACK;
                    ccp_pkg::CH_TAB: kind = ccp_pkg::KIND_TAB;
                    ccp_pkg::CH_CR:  kind = ccp_pkg::KIND_RET;
                    ccp_pkg::CH_LF:  kind = ccp_pkg::KIND_LINE;
                    default:         kind = ccp_pkg::KIND_PRINT;
                endcase
            end
            ccp_pkg::ACT_CLEAR: kind = ccp_pkg::KIND_CLEAR;
            ccp_pkg::ACT_READ: begin
                if (CMP_W'(i_cell_address) < CMP_W'(CELLS)) begin
                    kind = ccp_pkg::KIND_READ;
                end else begin
                    kind = ccp_pkg::KIND_NONE;
                end
            end
            default: kind = ccp_pkg::KIND_NONE;
        endcase
    end

    assign full      = (r_count == CNT_W'(DEPTH)) || i_hold;
    assign accept    = push && !full;
    assign o_cmd_vld = (r_count != '0);
    assign o_cmd     = r_q[r_rp];
    assign take      = i_cmd_take && o_cmd_vld;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (accept) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (take) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (accept && !take) begin
            n_count = r_count + 1'b1;
        end else if (take && !accept) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= '{kind: kind, char_code: i_char_code,
                           attribute: i_attribute, cell_address: i_cell_address};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Command queue count exceeds its depth.");

endmodule

// ----- sv/ccp_back.sv -----
// Back end: owns the cursor and the cell store, carries out commands and holds the result.
module ccp_back #(
    parameter int COLUMNS  = ccp_pkg::COLUMNS_DEF,
    parameter int ROWS     = ccp_pkg::ROWS_DEF,
    parameter int TAB_STOP = ccp_pkg::TAB_STOP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccp_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_vld,
    output logic                          o_cmd_take,
    output logic                          o_init,
    input  logic [ccp_pkg::ATTR_W-1:0]    i_blank_attr,
    output logic                          empty,
    input  logic                          pop,
    output logic [ccp_pkg::CURSOR_W-1:0]  o_cursor_position,
    output logic [ccp_pkg::WORD_W-1:0]    o_read_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_STOP);
    localparam int SUM_W  = COL_W + 5;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RESP   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [TAB_W-1:0]             r_phase, n_phase;
    logic [ADDR_W-1:0]            r_sweep, n_sweep;
    logic [ADDR_W-1:0]            r_wa, n_wa;
    logic                         r_pend, n_pend;
    logic                         r_init, n_init;
    logic                         r_is_read, n_is_read;
    logic                         r_out_vld, n_out_vld;
    logic [ccp_pkg::CURSOR_W-1:0] r_out_cursor, n_out_cursor;
    logic [ccp_pkg::WORD_W-1:0]   r_out_data, n_out_data;

    logic                         we, re;
    logic [ADDR_W-1:0]            waddr, raddr, lin;
    logic [ccp_pkg::WORD_W-1:0]   wdata, rdata;
    logic [SUM_W-1:0]             col_sum;
    logic [TAB_W-1:0]             phase_step;
    logic [ROW_W:0]               row_sum;
    logic                         row_inc, wrap, scroll, out_free;

    ccp_ram #(
        .WIDTH (ccp_pkg::WORD_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign lin = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);

    always_comb begin
        col_sum    = SUM_W'(r_col);
        phase_step = r_phase;
        row_inc    = 1'b0;
        case (i_cmd.kind)
            ccp_pkg::KIND_PRINT: begin
                col_sum    = SUM_W'(r_col) + 1'b1;
                phase_step = (r_phase == TAB_W'(TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
            end
            ccp_pkg::KIND_BACK: begin
                if (r_col != '0) begin
                    col_sum    = SUM_W'(r_col) - 1'b1;
                    phase_step = (r_phase == '0) ? TAB_W'(TAB_STOP - 1) : r_phase - 1'b1;
                end
            end
            ccp_pkg::KIND_TAB: begin
                col_sum    = SUM_W'(r_col) + SUM_W'(TAB_STOP) - SUM_W'(r_phase);
                phase_step = '0;
            end
            ccp_pkg::KIND_RET: begin
                col_sum    = '0;
                phase_step = '0;
            end
            ccp_pkg::KIND_LINE: begin
                col_sum    = '0;
                phase_step = '0;
                row_inc    = 1'b1;
            end
            default: begin
                col_sum    = SUM_W'(r_col);
                phase_step = r_phase;
            end
        endcase
        wrap = (col_sum >= SUM_W'(COLUMNS));
        if (wrap) begin
            col_sum    = '0;
            phase_step = '0;
            row_inc    = 1'b1;
        end
        row_sum = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(row_inc);
        scroll  = (row_sum == (ROW_W + 1)'(ROWS));
    end

    assign out_free = !r_out_vld || pop;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_phase      = r_phase;
        n_sweep      = r_sweep;
        n_wa         = r_wa;
        n_pend       = r_pend;
        n_init       = r_init;
        n_is_read    = r_is_read;
        n_out_vld    = r_out_vld && !pop;
        n_out_cursor = r_out_cursor;
        n_out_data   = r_out_data;
        o_cmd_take   = 1'b0;
        we           = 1'b0;
        waddr        = lin;
        wdata        = {i_cmd.attribute, i_cmd.char_code};
        re           = 1'b0;
        raddr        = ADDR_W'(i_cmd.cell_address);
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_take = 1'b1;
                    n_is_read  = (i_cmd.kind == ccp_pkg::KIND_READ);
                    re         = (i_cmd.kind == ccp_pkg::KIND_READ);
                    if (i_cmd.kind == ccp_pkg::KIND_CLEAR) begin
                        n_sweep = '0;
                        n_state = ST_FILL;
                    end else begin
                        we      = (i_cmd.kind == ccp_pkg::KIND_PRINT);
                        n_col   = COL_W'(col_sum);
                        n_phase = phase_step;
                        if (scroll) begin
                            n_row   = ROW_W'(ROWS - 1);
                            n_sweep = '0;
                            n_pend  = 1'b0;
                            n_state = ST_SCROLL;
                        end else begin
                            n_row   = ROW_W'(row_sum);
                            n_state = ST_RESP;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_cursor = ccp_pkg::CURSOR_W'(lin);
                    n_out_data   = r_is_read ? rdata : '0;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                re     = 1'b1;
                raddr  = r_sweep + ADDR_W'(COLUMNS);
                we     = r_pend;
                waddr  = r_wa;
                wdata  = rdata;
                n_wa   = r_sweep;
                n_pend = 1'b1;
                if (r_sweep == ADDR_W'(CELLS - COLUMNS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_DRAIN: begin
                we      = 1'b1;
                waddr   = r_wa;
                wdata   = rdata;
                n_pend  = 1'b0;
                n_sweep = ADDR_W'(CELLS - COLUMNS);
                n_state = ST_FILL;
            end
            ST_FILL: begin
                we    = 1'b1;
                waddr = r_sweep;
                wdata = r_init ? ccp_pkg::RESET_WORD : {i_blank_attr, ccp_pkg::CH_SPACE};
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_RESP;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_col     <= '0;
            r_row     <= '0;
            r_phase   <= '0;
            r_sweep   <= '0;
            r_pend    <= 1'b0;
            r_init    <= 1'b1;
            r_is_read <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_phase   <= n_phase;
            r_sweep   <= n_sweep;
            r_pend    <= n_pend;
            r_init    <= n_init;
            r_is_read <= n_is_read;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa         <= n_wa;
        r_out_cursor <= n_out_cursor;
        r_out_data   <= n_out_data;
    end

    assign o_init            = r_init;
    assign empty             = !r_out_vld;
    assign o_cursor_position = r_out_cursor;
    assign o_read_data       = r_out_data;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ROW_W + 1)'(r_row) < (ROW_W + 1)'(ROWS))
        else $error("Cursor row left the screen.");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (COL_W + 1)'(r_col) < (COL_W + 1)'(COLUMNS))
        else $error("Cursor column left the screen.");

    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_cmd_take)
        else $error("Command taken during the reset clearing pass.");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> (r_row == ROW_W'(ROWS - 1)))
        else $error("Cursor not on the last row while scrolling.");

endmodule

// ----- sv/text_console_char_put_core.sv -----
// Top level of the text console put engine with its configuration register.
//
//  Channel   Direction  Handshake               Payload
//  request   in         push / full             i_action, i_char_code, i_attribute,
//                                               i_cell_address
//  result    out        empty / pop             o_cursor_position, o_read_data
//  config    in         psel, penable, pwrite,  paddr, pwdata, prdata
//                       pready
//
//  Up to two requests wait in the command queue between front and back.
//  Clear walks the cell store with one write port.
//  A scroll copies one cell a cycle through the store's read and write ports and then
//  blanks the last row. After reset, full stays high while the store is cleared.
//  A result that is not popped holds the back end; the front keeps taking requests
//  until its command queue is full.
module text_console_char_put_core #(
    parameter int COLUMNS  = ccp_pkg::COLUMNS_DEF,
    parameter int ROWS     = ccp_pkg::ROWS_DEF,
    parameter int TAB_STOP = ccp_pkg::TAB_STOP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [ccp_pkg::ACTION_W-1:0]       i_action,
    input  logic [ccp_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [ccp_pkg::ATTR_W-1:0]         i_attribute,
    input  logic [ccp_pkg::CELL_ADDR_W-1:0]    i_cell_address,
    output logic                               empty,
    input  logic                               pop,
    output logic [ccp_pkg::CURSOR_W-1:0]       o_cursor_position,
    output logic [ccp_pkg::WORD_W-1:0]         o_read_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ccp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ccp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ccp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    ccp_pkg::t_cmd               cmd;
    logic                        cmd_vld;
    logic                        cmd_take;
    logic                        init;
    logic                        reg_sel;
    logic [ccp_pkg::ATTR_W-1:0]  r_blank_attr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ccp_pkg::APB_ADDR_W-1:2] == ccp_pkg::REG_BLANK_ATTR);
    assign prdata  = reg_sel ? ccp_pkg::APB_DATA_W'(r_blank_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= ccp_pkg::BLANK_ATTR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_blank_attr <= pwdata[ccp_pkg::ATTR_W-1:0];
        end
    end

    ccp_front #(
        .CELLS (COLUMNS * ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .i_cell_address (i_cell_address),
        .i_hold         (init),
        .o_cmd          (cmd),
        .o_cmd_vld      (cmd_vld),
        .i_cmd_take     (cmd_take)
    );

    ccp_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cmd_vld         (cmd_vld),
        .o_cmd_take        (cmd_take),
        .o_init            (init),
        .i_blank_attr      (r_blank_attr),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_position (o_cursor_position),
        .o_read_data       (o_read_data)
    );

endmodule
